[rtl/core/ste_pkg.sv]
// Shared types and constants for the sparse triangle extract unit.
package ste_pkg;

	localparam int unsigned IDX_W   = 31;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned PADDR_W = 4;

	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_START = 2'd0,
		MODE_ENTRY = 2'd1,
		MODE_END   = 2'd2,
		MODE_NONE  = 2'd3
	} ste_mode_t;

	typedef enum logic {
		KIND_ENTRY   = 1'b0,
		KIND_POINTER = 1'b1
	} ste_kind_t;

	typedef enum logic [1:0] {
		REG_KEEP_BEFORE = 2'd0,
		REG_UNIT_DIAG   = 2'd1,
		REG_SRC_BASE    = 2'd2,
		REG_TGT_BASE    = 2'd3
	} ste_reg_t;

	typedef struct packed {
		logic keep_before;
		logic unit_diag;
		logic src_base;
		logic tgt_base;
	} ste_cfg_t;

	typedef struct packed {
		logic             emit;
		ste_kind_t        kind;
		logic [IDX_W-1:0] out_index;
		logic [IDX_W-1:0] pointer_value;
		logic             clr_cnt;
		logic             inc_seq;
		logic             inc_kept;
	} ste_dec_t;

endpackage

[rtl/core/ste_in_if.sv]
// Input item channel: valid/ready handshake with mode, index and value.
interface ste_in_if #(
	parameter int unsigned VALUE_BITS = 64
);
	import ste_pkg::*;

	logic                  valid;
	logic                  ready;
	ste_mode_t             mode;
	logic [IDX_W-1:0]      entry_index;
	logic [VALUE_BITS-1:0] entry_value;

	modport source (output valid, output mode, output entry_index, output entry_value,
		input ready);
	modport sink (input valid, input mode, input entry_index, input entry_value,
		output ready);
endinterface

[rtl/core/ste_out_if.sv]
// Result channel: valid/ready handshake with kept entry or sequence pointer.
interface ste_out_if #(
	parameter int unsigned VALUE_BITS = 64
);
	import ste_pkg::*;

	logic                  valid;
	logic                  ready;
	ste_kind_t             kind;
	logic [IDX_W-1:0]      out_index;
	logic [VALUE_BITS-1:0] out_value;
	logic [IDX_W-1:0]      pointer_value;

	modport source (output valid, output kind, output out_index, output out_value,
		output pointer_value, input ready);
	modport sink (input valid, input kind, input out_index, input out_value,
		input pointer_value, output ready);
endinterface

[rtl/core/sparse_triangle_extract_unit.sv]
// Top level of the sparse triangle extract unit: staging, counters and result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  item     | in  | valid / ready      | mode, entry_index, entry_value
//  result   | out | valid / ready      | kind, out_index, out_value, pointer_value
//  apb      | in  | psel / penable     | pwrite, paddr, pwdata -> prdata, pready
//
// Flow: one item per clock unless a held result stalls the input stage; the input
// stage captures an item at the accepting edge and the result register takes it
// over once the result register is free.
// Reset: arst_n clears valid flags and both counters and loads the register
// defaults (keep before diagonal, diagonal kept, both bases zero).
// Stalls: a held result blocks the input stage only when that stage has a result
// to hand over; items that emit nothing drain past a stalled output.
module sparse_triangle_extract_unit
	import ste_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 32,
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	ste_in_if.sink             item,
	ste_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [INDEX_BITS-1:0] CNT_MAX = {INDEX_BITS{1'b1}};

	ste_cfg_t cfg;
	ste_dec_t dec;

	// Input stage
	logic                  valid_s1;
	ste_mode_t             mode_s1;
	logic [IDX_W-1:0]      index_s1;
	logic [VALUE_BITS-1:0] value_s1;

	// Sequence and kept counters
	logic [INDEX_BITS-1:0] seq_q;
	logic [INDEX_BITS-1:0] kept_q;

	// Result stage
	logic                  valid_s2;
	ste_kind_t             kind_s2;
	logic [IDX_W-1:0]      index_s2;
	logic [VALUE_BITS-1:0] value_s2;
	logic [IDX_W-1:0]      ptr_s2;

	logic s2_free;
	logic s1_adv;
	logic in_fire;

	ste_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ste_decide #(
		.INDEX_BITS (INDEX_BITS)
	) u_decide (
		.cfg         (cfg),
		.mode        (mode_s1),
		.entry_index (index_s1),
		.seq_cnt     (seq_q),
		.kept_cnt    (kept_q),
		.dec         (dec)
	);

	// The result register frees up when empty or when its transaction completes.
	assign s2_free    = !valid_s2 || result.ready;
	// Advance the input stage when its outcome has somewhere to go.
	assign s1_adv     = valid_s1 && (!dec.emit || s2_free);
	assign item.ready = !valid_s1 || s1_adv;
	assign in_fire    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1  <= item.mode;
			index_s1 <= item.entry_index;
			value_s1 <= item.entry_value;
		end
	end

	// Counters move once per transaction as it leaves the input stage; both saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			kept_q <= '0;
		end else if (s1_adv) begin
			if (dec.clr_cnt) begin
				seq_q  <= '0;
				kept_q <= '0;
			end else begin
				if (dec.inc_seq && seq_q != CNT_MAX) begin
					seq_q <= seq_q + INDEX_BITS'(1);
				end
				if (dec.inc_kept && kept_q != CNT_MAX) begin
					kept_q <= kept_q + INDEX_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && dec.emit;
		end
	end

	// Pointer results carry zero index and value; kept entries carry zero pointer.
	always_ff @(posedge clk) begin
		if (s1_adv && dec.emit && s2_free) begin
			kind_s2  <= dec.kind;
			index_s2 <= dec.out_index;
			value_s2 <= (dec.kind == KIND_ENTRY) ? value_s1 : '0;
			ptr_s2   <= dec.pointer_value;
		end
	end

	assign result.valid         = valid_s2;
	assign result.kind          = kind_s2;
	assign result.out_index     = index_s2;
	assign result.out_value     = value_s2;
	assign result.pointer_value = ptr_s2;

	// A start transaction leaves both counters cleared.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && mode_s1 == MODE_START |=> seq_q == '0 && kept_q == '0)
		else $error("counters not cleared after start");

	// A kept entry bumps the kept count by one unless it is saturated.
	a_kept_step: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && dec.inc_kept && !dec.clr_cnt |=>
		kept_q == $past(kept_q) + INDEX_BITS'(1) || $past(kept_q) == CNT_MAX)
		else $error("kept count did not advance");

	// Only a start transaction may lower the kept count.
	a_kept_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && mode_s1 == MODE_START) |=> kept_q >= $past(kept_q))
		else $error("kept count dropped");

	// A kept entry result never carries a pointer.
	a_entry_no_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == KIND_ENTRY |-> ptr_s2 == '0)
		else $error("entry result with nonzero pointer");

	// The input stage never advances an emitting transaction into an occupied result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(index_s2) && $stable(ptr_s2))
		else $error("held result overwritten");

endmodule

[rtl/core/ste_cfg.sv]
// APB-style configuration register file for the sparse triangle extract unit.
module ste_cfg
	import ste_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output ste_cfg_t           cfg
);

	ste_cfg_t cfg_q;
	ste_reg_t reg_sel;
	logic     wr_en;
	logic     rd_bit;

	assign reg_sel = ste_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_before <= 1'b1;
			cfg_q.unit_diag   <= 1'b0;
			cfg_q.src_base    <= 1'b0;
			cfg_q.tgt_base    <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_KEEP_BEFORE: cfg_q.keep_before <= pwdata[0];
				REG_UNIT_DIAG:   cfg_q.unit_diag   <= pwdata[0];
				REG_SRC_BASE:    cfg_q.src_base    <= pwdata[0];
				REG_TGT_BASE:    cfg_q.tgt_base    <= pwdata[0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_KEEP_BEFORE: rd_bit = cfg_q.keep_before;
			REG_UNIT_DIAG:   rd_bit = cfg_q.unit_diag;
			REG_SRC_BASE:    rd_bit = cfg_q.src_base;
			REG_TGT_BASE:    rd_bit = cfg_q.tgt_base;
			default:         rd_bit = 1'b0;
		endcase
	end

	assign prdata = {{(PDATA_W-1){1'b0}}, rd_bit};

endmodule

[rtl/core/ste_decide.sv]
// Triangle test, index rebasing and pointer formation for one staged item.
module ste_decide
	import ste_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 32
) (
	input  ste_cfg_t              cfg,
	input  ste_mode_t             mode,
	input  logic [IDX_W-1:0]      entry_index,
	input  logic [INDEX_BITS-1:0] seq_cnt,
	input  logic [INDEX_BITS-1:0] kept_cnt,
	output ste_dec_t              dec
);

	localparam int unsigned CW = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
	localparam int unsigned PW = (INDEX_BITS > IDX_W + 1) ? INDEX_BITS : IDX_W + 1;

	logic             neg;
	logic [IDX_W-1:0] minor;
	logic             lt;
	logic             eq;
	logic             keep;
	logic [IDX_W:0]   oi_sum;
	logic [IDX_W-1:0] oi;
	logic [PW-1:0]    kept_ext;
	logic [IDX_W:0]   ptr_sum;
	logic [IDX_W-1:0] ptr;

	// An index below the source base sits before every sequence index.
	assign neg   = (entry_index == '0) && cfg.src_base;
	assign minor = neg ? '0 : entry_index - IDX_W'(cfg.src_base);
	assign lt    = neg || (CW'(minor) < CW'(seq_cnt));
	assign eq    = !neg && (CW'(minor) == CW'(seq_cnt));

	always_comb begin
		if (eq) begin
			keep = !cfg.unit_diag;
		end else if (cfg.keep_before) begin
			keep = lt;
		end else begin
			keep = !lt;
		end
	end

	assign oi_sum = {1'b0, minor} + (IDX_W+1)'(cfg.tgt_base);
	assign oi     = neg ? '0 : (oi_sum[IDX_W] ? IDX_MAX : oi_sum[IDX_W-1:0]);

	// Saturate the pointer at the top of the 31-bit output range.
	assign kept_ext = PW'(kept_cnt);
	assign ptr_sum  = {1'b0, kept_ext[IDX_W-1:0]} + (IDX_W+1)'(cfg.tgt_base);

	always_comb begin
		if (kept_ext > PW'(IDX_MAX)) begin
			ptr = IDX_MAX;
		end else if (ptr_sum[IDX_W]) begin
			ptr = IDX_MAX;
		end else begin
			ptr = ptr_sum[IDX_W-1:0];
		end
	end

	always_comb begin
		dec               = '0;
		dec.kind          = KIND_POINTER;
		case (mode)
			MODE_START: begin
				dec.emit          = 1'b1;
				dec.clr_cnt       = 1'b1;
				dec.pointer_value = cfg.tgt_base ? IDX_W'(1) : '0;
			end
			MODE_END: begin
				dec.emit          = 1'b1;
				dec.inc_seq       = 1'b1;
				dec.pointer_value = ptr;
			end
			MODE_ENTRY: begin
				dec.emit      = keep;
				dec.inc_kept  = keep;
				dec.kind      = KIND_ENTRY;
				dec.out_index = oi;
			end
			default: begin
				dec.emit = 1'b0;
			end
		endcase
	end

endmodule

[verif/sparse_triangle_extract_unit_test.sv]
// Testbench for sparse_triangle_extract_unit: directed and random streams checked in order.
`timescale 1ns / 100ps

module sparse_triangle_extract_unit_test;
	import ste_pkg::*;

	// Counter width of the block and the 31-bit output ceiling.
	localparam logic [31:0]      CNT_SAT   = 32'hFFFF_FFFF;
	localparam logic [IDX_W-1:0] OUT_SAT   = IDX_MAX;
	// Edges to let pass after the last result so that silent items leave the pipeline.
	localparam int unsigned      FLUSH_CYC = 6;
	localparam int unsigned      DRAIN_MAX = 50000;

	typedef struct packed {
		ste_kind_t        kind;
		logic [IDX_W-1:0] out_index;
		logic [63:0]      out_value;
		logic [IDX_W-1:0] pointer_value;
	} tri_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ste_in_if  #(.VALUE_BITS(64)) item_ch ();
	ste_out_if #(.VALUE_BITS(64)) result_ch ();

	sparse_triangle_extract_unit #(
		.INDEX_BITS(32),
		.VALUE_BITS(64)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: the register copy and the two running counters.
	ste_cfg_t    shadow_cfg;
	logic [31:0] seq_idx;
	logic [31:0] kept_total;

	// Results still owed by the block, oldest first.
	tri_result_t owed_results[$];

	int unsigned error_count;
	int unsigned counted_items;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned rx_hold_len;
	int unsigned rx_hold_tag;

	// Free-running clock, period 2 ns.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Global watchdog: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("sparse_triangle_extract_unit_test: errors");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	function automatic logic [IDX_W-1:0] current_pointer();
		logic [32:0] sum;
		if (kept_total > {1'b0, OUT_SAT})
			return OUT_SAT;
		sum = {1'b0, kept_total} + shadow_cfg.tgt_base;
		return (sum > {2'b0, OUT_SAT}) ? OUT_SAT : sum[IDX_W-1:0];
	endfunction

	// Apply one accepted transaction to the predictor; queue the result it causes, if any.
	function automatic void predict_transaction(input ste_mode_t mode,
		input logic [IDX_W-1:0] idx, input logic [63:0] val);
		tri_result_t res;
		logic below_base;
		logic [IDX_W-1:0] minor;
		logic lt, eq, keep;
		logic [31:0] shifted;
		res = '0;
		case (mode)
			MODE_START: begin
				seq_idx = '0;
				kept_total = '0;
				res.kind = KIND_POINTER;
				res.pointer_value = current_pointer();
				owed_results.push_back(res);
			end
			MODE_END: begin
				res.kind = KIND_POINTER;
				res.pointer_value = current_pointer();
				owed_results.push_back(res);
				if (seq_idx != CNT_SAT)
					seq_idx = seq_idx + 1;
			end
			MODE_ENTRY: begin
				// An index under the source base counts as minus one: before every sequence.
				below_base = (idx == '0) && shadow_cfg.src_base;
				minor = below_base ? '0 : idx - shadow_cfg.src_base;
				lt = below_base || ({1'b0, minor} < seq_idx);
				eq = !below_base && ({1'b0, minor} == seq_idx);
				if (eq)
					keep = !shadow_cfg.unit_diag;
				else if (shadow_cfg.keep_before)
					keep = lt;
				else
					keep = !lt;
				if (keep) begin
					shifted = {1'b0, minor} + shadow_cfg.tgt_base;
					res.kind = KIND_ENTRY;
					if (below_base)
						res.out_index = '0;
					else
						res.out_index = (shifted > {1'b0, OUT_SAT}) ? OUT_SAT : shifted[IDX_W-1:0];
					res.out_value = val;
					if (kept_total != CNT_SAT)
						kept_total = kept_total + 1;
					owed_results.push_back(res);
				end
			end
			default: ;
		endcase
	endfunction

	// Check every result transaction against the oldest owed result.
	always @(posedge clk) begin
		tri_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d idx=%0h ptr=%0h",
					result_ch.kind, result_ch.out_index, result_ch.pointer_value));
			end else begin
				want = owed_results.pop_front();
				if (result_ch.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", result_ch.kind, want.kind));
				if (result_ch.out_index !== want.out_index)
					report_mismatch($sformatf("out_index %0h, want %0h",
						result_ch.out_index, want.out_index));
				if (result_ch.out_value !== want.out_value)
					report_mismatch($sformatf("out_value %0h, want %0h",
						result_ch.out_value, want.out_value));
				if (result_ch.pointer_value !== want.pointer_value)
					report_mismatch($sformatf("pointer_value %0h, want %0h",
						result_ch.pointer_value, want.pointer_value));
			end
		end
	end

	// Drive result ready: random stalls, or a long hold when a test asks for one.
	initial begin
		int unsigned hold_left;
		int unsigned seen_tag;
		hold_left = 0;
		seen_tag = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (seen_tag != rx_hold_tag) begin
				seen_tag = rx_hold_tag;
				hold_left = rx_hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offer one item; entered and left at a falling edge. Valid stays high between items unless an idle gap is drawn.
	task automatic send_item(input ste_mode_t mode, input logic [IDX_W-1:0] idx,
		input logic [63:0] val);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.mode        <= mode;
		item_ch.entry_index <= idx;
		item_ch.entry_value <= val;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predict_transaction(mode, idx, val);
		if (mode != MODE_NONE)
			counted_items++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		return {$urandom(), $urandom()};
	endfunction

	// Drop valid and wait until the block owes nothing and its pipeline is empty.
	task automatic settle();
		int unsigned waited;
		item_ch.valid <= 1'b0;
		waited = 0;
		while (owed_results.size() != 0) begin
			@(posedge clk);
			waited++;
			if (waited > DRAIN_MAX) begin
				$display("sparse_triangle_extract_unit_test: errors");
				$finish;
			end
		end
		repeat (FLUSH_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write of one register, then read it back.
	task automatic write_reg(input ste_reg_t r, input logic v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= {{(PDATA_W-1){1'b0}}, v};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (r)
			REG_KEEP_BEFORE: shadow_cfg.keep_before = v;
			REG_UNIT_DIAG:   shadow_cfg.unit_diag   = v;
			REG_SRC_BASE:    shadow_cfg.src_base    = v;
			REG_TGT_BASE:    shadow_cfg.tgt_base    = v;
			default: ;
		endcase
		// Turn the access straight into a read setup; psel stays high.
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {{(PDATA_W-1){1'b0}}, v})
			report_mismatch($sformatf("register %0d reads %0h, want %0d", r, prdata, v));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_config(input logic kb, input logic ud, input logic sb, input logic tb);
		write_reg(REG_KEEP_BEFORE, kb);
		write_reg(REG_UNIT_DIAG, ud);
		write_reg(REG_SRC_BASE, sb);
		write_reg(REG_TGT_BASE, tb);
	endtask

	// Reset settings: entries before any start, ignored mode, diagonal kept, far index dropped.
	task automatic test_reset_defaults();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_item(MODE_ENTRY, '0, '1);
		send_item(MODE_NONE, IDX_MAX, rand_value());
		send_item(MODE_START, IDX_MAX, '1);
		send_item(MODE_ENTRY, 31'd0, rand_value());
		send_item(MODE_ENTRY, 31'd1, rand_value());
		send_item(MODE_ENTRY, IDX_MAX, rand_value());
		send_item(MODE_END, '0, '0);
		send_item(MODE_ENTRY, 31'd0, '0);
		send_item(MODE_ENTRY, 31'd1, rand_value());
		send_item(MODE_ENTRY, 31'd2, rand_value());
		send_item(MODE_END, IDX_MAX, '1);
		settle();
	endtask

	// Both bases set, unit diagonal: index under the source base kept at zero, diagonal dropped.
	task automatic test_base_shift();
		apply_config(1'b1, 1'b1, 1'b1, 1'b1);
		send_item(MODE_START, '0, '0);
		send_item(MODE_ENTRY, 31'd0, '1);
		send_item(MODE_ENTRY, 31'd1, rand_value());
		send_item(MODE_END, '0, '0);
		send_item(MODE_ENTRY, 31'd1, rand_value());
		send_item(MODE_ENTRY, 31'd2, rand_value());
		send_item(MODE_END, '0, '0);
		settle();
	endtask

	// Upper side with target base: the largest index saturates, lower entries dropped.
	task automatic test_upper_side();
		apply_config(1'b0, 1'b0, 1'b0, 1'b1);
		send_item(MODE_START, '0, '0);
		send_item(MODE_ENTRY, IDX_MAX, '1);
		send_item(MODE_ENTRY, 31'd0, rand_value());
		send_item(MODE_END, '0, '0);
		send_item(MODE_ENTRY, 31'd0, rand_value());
		settle();
		apply_config(1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	// Hold result ready low for a long stretch while items keep coming, so the input stalls.
	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_config(1'b1, 1'b0, 1'b0, 1'b0);
		rx_hold_len = 300;
		rx_hold_tag++;
		send_item(MODE_START, '0, rand_value());
		for (int s = 0; s < 8; s++) begin
			for (int e = 0; e < 4; e++)
				send_item(MODE_ENTRY, IDX_W'($urandom_range(0, s + 2)), rand_value());
			send_item(MODE_END, '0, rand_value());
		end
		settle();
	endtask

	// Pick an entry index: mostly near the diagonal, sometimes anywhere, sometimes an extreme.
	function automatic logic [IDX_W-1:0] pick_index();
		int unsigned r;
		longint near;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			near = longint'(seq_idx) + shadow_cfg.src_base + $urandom_range(0, 4) - 2;
			if (near < 0)
				near = 0;
			return near[IDX_W-1:0];
		end
		if (r < 85)
			return IDX_W'($urandom());
		return $urandom_range(0, 1) ? IDX_MAX : '0;
	endfunction

	// One matrix with random shape; now and then a missing start or end, or stray noise.
	task automatic send_random_matrix();
		int unsigned n_seq;
		int unsigned n_ent;
		if ($urandom_range(0, 9) != 0)
			send_item(MODE_START, IDX_W'($urandom()), rand_value());
		n_seq = $urandom_range(1, 6);
		for (int s = 0; s < n_seq; s++) begin
			n_ent = $urandom_range(0, 5);
			for (int e = 0; e < n_ent; e++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(MODE_NONE, IDX_W'($urandom()), rand_value());
				send_item(MODE_ENTRY, pick_index(), rand_value());
			end
			if ($urandom_range(0, 14) != 0)
				send_item(MODE_END, IDX_W'($urandom()), rand_value());
		end
	endtask

	task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
		input int unsigned target);
		int unsigned stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = counted_items + target;
		while (counted_items < stop_at) begin
			// Change settings only between matrices, with the block drained.
			if ($urandom_range(0, 3) == 0) begin
				settle();
				apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			send_random_matrix();
		end
		settle();
	endtask

	initial begin
		error_count   = 0;
		counted_items = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		rx_hold_len   = 0;
		rx_hold_tag   = 0;
		shadow_cfg    = '{keep_before: 1'b1, unit_diag: 1'b0, src_base: 1'b0, tgt_base: 1'b0};
		seq_idx       = '0;
		kept_total    = '0;
		arst_n        = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_NONE;
		item_ch.entry_index = '0;
		item_ch.entry_value = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;

		// Hold reset, then release it away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_base_shift();
		test_upper_side();
		test_output_stall();
		test_random_traffic(30, 46, 370);
		test_random_traffic(46, 30, 370);
		test_random_traffic(0, 0, 370);

		if (error_count == 0)
			$display("sparse_triangle_extract_unit_test: clean");
		else
			$display("sparse_triangle_extract_unit_test: errors");
		$finish;
	end

endmodule
